### hdl/sit_pkg.sv
// Package for the stream id tagger: shared types, register codes and constants.
// No dependencies; every other file but sit_queue takes names from here by scope.
package sit_pkg;

   localparam int unsigned CHUNKS_DEFAULT = 4096;
   localparam int unsigned SECTOR_SHIFT = 9;
   localparam int unsigned NS_PER_SEC = 1000000000;

   localparam int unsigned SECTOR_W = 48;
   localparam int unsigned LEN_W = 32;
   localparam int unsigned LENBLK_W = LEN_W - SECTOR_SHIFT;
   localparam int unsigned NOW_W = 64;
   localparam int unsigned COUNT_W = 32;
   localparam int unsigned STREAM_W = 5;
   localparam int unsigned HINT_W = 6;
   localparam int unsigned CSIZE_W = 31;
   localparam int unsigned DECAY_W = 16;
   localparam int unsigned PERIOD_W = 46;
   localparam int unsigned END_W = SECTOR_W + 1;

   localparam int unsigned CSR_IDX_W = 2;
   localparam int unsigned CSR_DATA_W = 31;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_CHUNK_SIZE = 2'd0,
      CSR_DECAY      = 2'd1,
      CSR_STREAMS    = 2'd2
   } csr_index_type;

   localparam logic [CSIZE_W-1:0]  CHUNK_SIZE_RESET = 31'd2097152;
   localparam logic [DECAY_W-1:0]  DECAY_RESET = 16'd10;
   localparam logic [STREAM_W-1:0] STREAMS_RESET = 5'd16;

   typedef struct packed {
      logic [COUNT_W-1:0]  count;
      logic [STREAM_W-1:0] stream;
      logic [NOW_W-1:0]    stamp;
   } chunk_entry_type;

   typedef struct packed {
      logic [HINT_W-1:0] stream_hint;
      logic              was_sequential;
      logic              out_of_range;
   } result_type;

   typedef struct packed {
      logic [CSIZE_W-1:0]  chunk_size;
      logic [PERIOD_W-1:0] period_ns;
      logic [STREAM_W-1:0] streams;
   } cfg_type;

endpackage

### hdl/sit_if.sv
// Channel interfaces for the stream id tagger: request, response and register write.
// Depends on sit_pkg for field widths.
interface sit_req_if;
   logic                              valid;
   logic                              ready;
   logic [sit_pkg::SECTOR_W-1:0]      start_sector;
   logic [sit_pkg::LEN_W-1:0]         length_bytes;
   logic [sit_pkg::NOW_W-1:0]         now_ns;
   modport source (output valid, start_sector, length_bytes, now_ns, input ready);
   modport sink (input valid, start_sector, length_bytes, now_ns, output ready);
endinterface

interface sit_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [sit_pkg::HINT_W-1:0]  stream_hint;
   logic                        was_sequential;
   logic                        out_of_range;
   modport source (output valid, stream_hint, was_sequential, out_of_range, input ready);
   modport sink (input valid, stream_hint, was_sequential, out_of_range, output ready);
endinterface

interface sit_csr_if;
   logic                           valid;
   logic                           ready;
   logic [sit_pkg::CSR_IDX_W-1:0]  index;
   logic [sit_pkg::CSR_DATA_W-1:0] data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

### hdl/sit_front.sv
// Front end: accept a request and find its chunk by restoring division, one bit a cycle.
// Depends on sit_pkg.
module sit_front #(
   parameter int unsigned CHUNKS = sit_pkg::CHUNKS_DEFAULT,
   localparam int unsigned QW = $clog2(CHUNKS + 1),
   localparam int unsigned IW = (CHUNKS > 1) ? $clog2(CHUNKS) : 1,
   localparam int unsigned QDW = sit_pkg::SECTOR_W + sit_pkg::LENBLK_W + sit_pkg::NOW_W
                                 + IW + 1
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [sit_pkg::SECTOR_W-1:0]  start_sector,
   input  logic [sit_pkg::LEN_W-1:0]     length_bytes,
   input  logic [sit_pkg::NOW_W-1:0]     now_ns,
   input  logic [sit_pkg::CSIZE_W-1:0]   chunk_size,
   output logic                          push_valid,
   input  logic                          push_ready,
   output logic [QDW-1:0]                push_data
);
   localparam int unsigned DW = sit_pkg::SECTOR_W + sit_pkg::SECTOR_SHIFT;
   localparam int unsigned DVW = sit_pkg::CSIZE_W + QW - 1;
   localparam int unsigned KW = (QW > 1) ? $clog2(QW) : 1;
   localparam int unsigned MW = 64;

   typedef enum logic [1:0] {F_IDLE, F_DIV, F_PUSH} state_type;

   state_type                     state_ff;
   logic [DW-1:0]                 rem_ff;
   logic [DVW-1:0]                dvs_ff;
   logic [QW-1:0]                 q_ff;
   logic [KW-1:0]                 k_ff;
   logic [sit_pkg::SECTOR_W-1:0]  sector_ff;
   logic [sit_pkg::LENBLK_W-1:0]  lenblk_ff;
   logic [sit_pkg::NOW_W-1:0]     now_ff;
   logic                          oor_ff;

   logic [DW-1:0]  dividend_in;
   logic [MW-1:0]  limit_in;
   logic           fits_in;
   logic           oor_final;

   assign dividend_in = {start_sector, {sit_pkg::SECTOR_SHIFT{1'b0}}};
   assign limit_in = MW'({chunk_size, {QW{1'b0}}});
   assign fits_in = MW'(rem_ff) >= MW'(dvs_ff);
   assign oor_final = oor_ff || (q_ff >= QW'(CHUNKS));

   assign req_ready = (state_ff == F_IDLE);
   assign push_valid = (state_ff == F_PUSH);
   assign push_data = {sector_ff, lenblk_ff, now_ff, q_ff[IW-1:0], oor_final};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
      end else begin
         unique case (state_ff)
            F_IDLE: begin
               if (req_valid) begin
                  sector_ff <= start_sector;
                  lenblk_ff <= length_bytes[sit_pkg::LEN_W-1:sit_pkg::SECTOR_SHIFT];
                  now_ff <= now_ns;
                  rem_ff <= dividend_in;
                  dvs_ff <= DVW'({chunk_size, {(QW-1){1'b0}}});
                  q_ff <= '0;
                  k_ff <= KW'(QW - 1);
                  if (chunk_size == '0 || MW'(dividend_in) >= limit_in) begin
                     oor_ff <= 1'b1;
                     state_ff <= F_PUSH;
                  end else begin
                     oor_ff <= 1'b0;
                     state_ff <= F_DIV;
                  end
               end
            end
            F_DIV: begin
               if (fits_in) begin
                  rem_ff <= rem_ff - DW'(dvs_ff);
               end
               q_ff <= QW'({q_ff, fits_in});
               dvs_ff <= dvs_ff >> 1;
               if (k_ff == '0) begin
                  state_ff <= F_PUSH;
               end else begin
                  k_ff <= k_ff - 1'b1;
               end
            end
            F_PUSH: begin
               if (push_ready) begin
                  state_ff <= F_IDLE;
               end
            end
            default: state_ff <= F_IDLE;
         endcase
      end
   end
endmodule

### hdl/sit_queue.sv
// Two-entry queue between the front and back ends.
// Depends on nothing.
module sit_queue #(
   parameter int unsigned WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  logic [WIDTH-1:0] in_data,
   output logic             out_valid,
   input  logic             out_ready,
   output logic [WIDTH-1:0] out_data
);
   logic [WIDTH-1:0] slot_ff [2];
   logic             wr_ff;
   logic             rd_ff;
   logic [1:0]       fill_ff;
   logic             push;
   logic             pop;

   assign in_ready = (fill_ff != 2'd2);
   assign out_valid = (fill_ff != 2'd0);
   assign out_data = slot_ff[rd_ff];
   assign push = in_valid && in_ready;
   assign pop = out_valid && out_ready;

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ff] <= in_data;
      end
      if (reset) begin
         wr_ff <= 1'b0;
         rd_ff <= 1'b0;
         fill_ff <= 2'd0;
      end else begin
         if (push) wr_ff <= ~wr_ff;
         if (pop) rd_ff <= ~rd_ff;
         fill_ff <= fill_ff + 2'(push) - 2'(pop);
      end
   end
endmodule

### hdl/sit_back.sv
// Back end: chunk table read-modify-write, decay division, stream choice, result register.
// Depends on sit_pkg.
module sit_back #(
   parameter int unsigned CHUNKS = sit_pkg::CHUNKS_DEFAULT,
   localparam int unsigned IW = (CHUNKS > 1) ? $clog2(CHUNKS) : 1,
   localparam int unsigned QDW = sit_pkg::SECTOR_W + sit_pkg::LENBLK_W + sit_pkg::NOW_W
                                 + IW + 1
) (
   input  logic                   clock,
   input  logic                   reset,
   input  sit_pkg::cfg_type       cfg,
   input  logic                   pop_valid,
   output logic                   pop_ready,
   input  logic [QDW-1:0]         pop_data,
   output logic                   clearing,
   output logic                   out_valid,
   input  logic                   out_ready,
   output sit_pkg::result_type    out_result
);
   localparam int unsigned DVW = sit_pkg::PERIOD_W + 4;

   typedef enum logic [2:0] {B_CLEAR, B_IDLE, B_READ, B_DIV, B_SHIFT, B_FIN} state_type;

   state_type                      state_ff;
   logic [IW-1:0]                  clr_ff;
   logic                           out_valid_ff;
   sit_pkg::result_type            result_ff;
   logic [sit_pkg::END_W-1:0]      last_end_ff;
   logic [sit_pkg::STREAM_W-1:0]   last_stream_ff;
   logic [sit_pkg::SECTOR_W-1:0]   sector_ff;
   logic [sit_pkg::LENBLK_W-1:0]   lenblk_ff;
   logic [sit_pkg::NOW_W-1:0]      now_ff;
   logic [IW-1:0]                  idx_ff;
   sit_pkg::chunk_entry_type       rd_ff;
   logic [sit_pkg::COUNT_W-1:0]    cnt_ff;
   logic [sit_pkg::NOW_W-1:0]      rem_ff;
   logic [DVW-1:0]                 dvs_ff;
   logic [2:0]                     k_ff;
   logic [4:0]                     halv_ff;

   sit_pkg::chunk_entry_type       mem [CHUNKS];

   logic [sit_pkg::SECTOR_W-1:0]   q_sector;
   logic [sit_pkg::LENBLK_W-1:0]   q_lenblk;
   logic [sit_pkg::NOW_W-1:0]      q_now;
   logic [IW-1:0]                  q_idx;
   logic                           q_oor;
   logic                           slot_free;
   logic                           take;
   logic                           res_load;
   logic [sit_pkg::NOW_W-1:0]      elapsed;
   logic                           fits;
   logic [sit_pkg::STREAM_W-1:0]   stream_new;
   logic                           seq;
   logic [sit_pkg::STREAM_W-1:0]   stream_use;
   logic                           mem_we;
   logic [IW-1:0]                  mem_wa;
   sit_pkg::chunk_entry_type       mem_wd;

   assign {q_sector, q_lenblk, q_now, q_idx, q_oor} = pop_data;
   assign slot_free = !out_valid_ff || out_ready;
   assign pop_ready = (state_ff == B_IDLE) && slot_free;
   assign take = pop_valid && pop_ready;
   assign res_load = (take && q_oor) || (state_ff == B_FIN);
   assign clearing = (state_ff == B_CLEAR);
   assign out_valid = out_valid_ff;
   assign out_result = result_ff;

   assign elapsed = now_ff - rd_ff.stamp;
   assign fits = rem_ff >= sit_pkg::NOW_W'(dvs_ff);
   assign seq = ({1'b0, sector_ff} == last_end_ff);
   assign stream_use = seq ? last_stream_ff : stream_new;

   // First stream whose ceiling covers the count, else the last; with none, keep the old.
   always_comb begin
      logic found;
      found = 1'b0;
      stream_new = rd_ff.stream;
      for (int i = 0; i < 31; i++) begin
         if (!found && (i < int'(cfg.streams))
             && ((33'(1) << (i + 1)) >= {1'b0, cnt_ff})) begin
            stream_new = sit_pkg::STREAM_W'(i);
            found = 1'b1;
         end
      end
      if (!found && cfg.streams != '0) begin
         stream_new = cfg.streams - 1'b1;
      end
   end

   always_comb begin
      mem_we = 1'b0;
      mem_wa = idx_ff;
      mem_wd = '{count: cnt_ff, stream: stream_new, stamp: now_ff};
      if (state_ff == B_CLEAR) begin
         mem_we = 1'b1;
         mem_wa = clr_ff;
         mem_wd = '0;
      end else if (state_ff == B_FIN) begin
         mem_we = 1'b1;
      end
   end

   // Read the entry when the request is taken and hold it through the update.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa] <= mem_wd;
      end
      if (take) begin
         rd_ff <= mem[q_idx];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= B_CLEAR;
         clr_ff <= '0;
         out_valid_ff <= 1'b0;
         last_end_ff <= '1;
         last_stream_ff <= '0;
      end else begin
         if (res_load) begin
            out_valid_ff <= 1'b1;
         end else if (out_ready) begin
            out_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            B_CLEAR: begin
               clr_ff <= clr_ff + 1'b1;
               if (clr_ff == IW'(CHUNKS - 1)) begin
                  state_ff <= B_IDLE;
               end
            end
            B_IDLE: begin
               if (take) begin
                  sector_ff <= q_sector;
                  lenblk_ff <= q_lenblk;
                  now_ff <= q_now;
                  idx_ff <= q_idx;
                  if (q_oor) begin
                     // Out-of-range chunk: answer at once, no table or last-end update.
                     result_ff <= '{stream_hint: '0, was_sequential: 1'b0, out_of_range: 1'b1};
                  end else begin
                     state_ff <= B_READ;
                  end
               end
            end
            B_READ: begin
               halv_ff <= '0;
               rem_ff <= elapsed;
               dvs_ff <= {cfg.period_ns, 4'b0};
               k_ff <= 3'd4;
               if (cfg.period_ns == '0) begin
                  cnt_ff <= rd_ff.count + 1'b1;
                  state_ff <= B_SHIFT;
               end else if (elapsed >= sit_pkg::NOW_W'({cfg.period_ns, 5'b0})) begin
                  cnt_ff <= '0;
                  state_ff <= B_SHIFT;
               end else begin
                  cnt_ff <= rd_ff.count + 1'b1;
                  state_ff <= B_DIV;
               end
            end
            B_DIV: begin
               if (fits) begin
                  rem_ff <= rem_ff - sit_pkg::NOW_W'(dvs_ff);
               end
               halv_ff <= {halv_ff[3:0], fits};
               dvs_ff <= dvs_ff >> 1;
               k_ff <= k_ff - 1'b1;
               if (k_ff == 3'd0) begin
                  state_ff <= B_SHIFT;
               end
            end
            B_SHIFT: begin
               cnt_ff <= cnt_ff >> halv_ff;
               state_ff <= B_FIN;
            end
            B_FIN: begin
               last_end_ff <= {1'b0, sector_ff} + sit_pkg::END_W'(lenblk_ff);
               last_stream_ff <= stream_use;
               result_ff <= '{stream_hint: sit_pkg::HINT_W'(stream_use) + 6'd2,
                              was_sequential: seq, out_of_range: 1'b0};
               state_ff <= B_IDLE;
            end
            default: state_ff <= B_IDLE;
         endcase
      end
   end
endmodule

### hdl/io_stream_id_tagger.sv
// Path: front end (request register, chunk division), queue, back end (table read, decay
//   division, shift, result register); an out-of-range chunk skips the back-end update.
// Throughput: each end takes a new request only when done with the last; the pace is set
//   by the one-bit-a-cycle chunk division in the front end.
// Reset: synchronous; afterwards the chunk table is cleared one entry a cycle with
//   req_ch.ready low; register writes are taken throughout.
module io_stream_id_tagger #(
   parameter int unsigned CHUNKS = sit_pkg::CHUNKS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   sit_req_if.sink     req_ch,
   sit_rsp_if.source   rsp_ch,
   sit_csr_if.sink     csr_ch
);
   localparam int unsigned IW = (CHUNKS > 1) ? $clog2(CHUNKS) : 1;
   localparam int unsigned QDW = sit_pkg::SECTOR_W + sit_pkg::LENBLK_W + sit_pkg::NOW_W
                                 + IW + 1;

   // Configuration registers.
   logic [sit_pkg::CSIZE_W-1:0]   chunk_size_ff;
   logic [sit_pkg::DECAY_W-1:0]   decay_ff;
   logic [sit_pkg::STREAM_W-1:0]  streams_ff;
   logic [sit_pkg::PERIOD_W-1:0]  period_ff;
   sit_pkg::cfg_type              cfg;

   logic                          front_ready;
   logic                          clearing;
   logic                          push_valid;
   logic                          push_ready;
   logic [QDW-1:0]                push_data;
   logic                          pop_valid;
   logic                          pop_ready;
   logic [QDW-1:0]                pop_data;
   sit_pkg::result_type           result;

   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      // Decay period in ns; one multiply, registered before use.
      period_ff <= sit_pkg::PERIOD_W'(decay_ff) * sit_pkg::PERIOD_W'(sit_pkg::NS_PER_SEC);
      if (reset) begin
         chunk_size_ff <= sit_pkg::CHUNK_SIZE_RESET;
         decay_ff <= sit_pkg::DECAY_RESET;
         streams_ff <= sit_pkg::STREAMS_RESET;
      end else if (csr_ch.valid) begin
         unique case (sit_pkg::csr_index_type'(csr_ch.index))
            sit_pkg::CSR_CHUNK_SIZE: chunk_size_ff <= csr_ch.data;
            sit_pkg::CSR_DECAY:      decay_ff <= csr_ch.data[sit_pkg::DECAY_W-1:0];
            sit_pkg::CSR_STREAMS:    streams_ff <= csr_ch.data[sit_pkg::STREAM_W-1:0];
            default: ;  // drop writes to unmapped indexes
         endcase
      end
   end

   assign cfg = '{chunk_size: chunk_size_ff, period_ns: period_ff, streams: streams_ff};

   // Hold off requests while the table clear sweep runs.
   assign req_ch.ready = front_ready && !clearing;

   sit_front #(.CHUNKS(CHUNKS)) u_front (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_ch.valid && !clearing),
      .req_ready    (front_ready),
      .start_sector (req_ch.start_sector),
      .length_bytes (req_ch.length_bytes),
      .now_ns       (req_ch.now_ns),
      .chunk_size   (chunk_size_ff),
      .push_valid   (push_valid),
      .push_ready   (push_ready),
      .push_data    (push_data)
   );

   sit_queue #(.WIDTH(QDW)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (push_valid),
      .in_ready  (push_ready),
      .in_data   (push_data),
      .out_valid (pop_valid),
      .out_ready (pop_ready),
      .out_data  (pop_data)
   );

   sit_back #(.CHUNKS(CHUNKS)) u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data),
      .clearing   (clearing),
      .out_valid  (rsp_ch.valid),
      .out_ready  (rsp_ch.ready),
      .out_result (result)
   );

   assign rsp_ch.stream_hint = result.stream_hint;
   assign rsp_ch.was_sequential = result.was_sequential;
   assign rsp_ch.out_of_range = result.out_of_range;

   a_oor_result: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && rsp_ch.out_of_range |-> rsp_ch.stream_hint == '0 && !rsp_ch.was_sequential)
      else $error("out-of-range beat carries a hint");

   a_hint_floor: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && !rsp_ch.out_of_range |-> rsp_ch.stream_hint >= 6'd2)
      else $error("in-range beat has hint below 2");

   a_no_accept_clear: assert property (@(posedge clock) disable iff (reset)
      clearing |-> !req_ch.ready && !pop_ready)
      else $error("request taken during table clear");
endmodule

### tb/sv/tb_top.sv
// Self-checking bench for io_stream_id_tagger: random and directed block requests,
// a per-chunk access-count predictor in a small scoreboard class, register phases.
// Depends on sit_pkg, the channel interfaces in sit_if.sv and io_stream_id_tagger.
module tb_top;

   // Track chunk heat, decay and stream choice; hold the results owed by the block.
   class hint_scoreboard;
      logic [sit_pkg::COUNT_W-1:0]  heat     [sit_pkg::CHUNKS_DEFAULT];
      logic [sit_pkg::STREAM_W-1:0] stream_of[sit_pkg::CHUNKS_DEFAULT];
      logic [sit_pkg::NOW_W-1:0]    stamp    [sit_pkg::CHUNKS_DEFAULT];
      logic [63:0]                  last_end;
      logic [sit_pkg::STREAM_W-1:0] last_stream;
      logic [sit_pkg::CSIZE_W-1:0]  chunk_size;
      logic [sit_pkg::DECAY_W-1:0]  decay_s;
      logic [sit_pkg::STREAM_W-1:0] streams;
      sit_pkg::result_type          owed[$];
      int                           errors;

      function new();
         foreach (heat[i]) begin
            heat[i] = '0;
            stream_of[i] = '0;
            stamp[i] = '0;
         end
         last_end = '1;
         last_stream = '0;
         chunk_size = sit_pkg::CHUNK_SIZE_RESET;
         decay_s = sit_pkg::DECAY_RESET;
         streams = sit_pkg::STREAMS_RESET;
         errors = 0;
      endfunction

      function void set_reg(sit_pkg::csr_index_type idx,
                            logic [sit_pkg::CSR_DATA_W-1:0] val);
         case (idx)
            sit_pkg::CSR_CHUNK_SIZE: chunk_size = val[sit_pkg::CSIZE_W-1:0];
            sit_pkg::CSR_DECAY:      decay_s = val[sit_pkg::DECAY_W-1:0];
            sit_pkg::CSR_STREAMS:    streams = val[sit_pkg::STREAM_W-1:0];
            default: ;
         endcase
      endfunction

      // Work out the hint for one accepted request and queue it.
      function void note_request(logic [sit_pkg::SECTOR_W-1:0] sector,
                                 logic [sit_pkg::LEN_W-1:0] len,
                                 logic [sit_pkg::NOW_W-1:0] now);
         sit_pkg::result_type          r;
         logic [63:0]                  chunk;
         logic [63:0]                  halvings;
         logic [sit_pkg::COUNT_W-1:0]  cnt;
         logic [sit_pkg::STREAM_W-1:0] st;
         bit                           seq;
         r = '0;
         chunk = '1;
         if (chunk_size != 0)
            chunk = ({16'd0, sector} << sit_pkg::SECTOR_SHIFT) / {33'd0, chunk_size};
         if (chunk >= sit_pkg::CHUNKS_DEFAULT) begin
            r.out_of_range = 1'b1;
            owed.push_back(r);
            return;
         end
         cnt = heat[chunk] + 1;
         if (decay_s != 0) begin
            halvings = (now - stamp[chunk]) / 64'd1000000000 / {48'd0, decay_s};
            cnt = (halvings >= 32) ? '0 : cnt >> halvings;
         end
         heat[chunk] = cnt;
         st = stream_of[chunk];
         for (int i = 0; i < streams; i++) begin
            st = sit_pkg::STREAM_W'(i);
            if ((64'd1 << (i + 1)) >= {32'd0, cnt}) break;
         end
         stream_of[chunk] = st;
         stamp[chunk] = now;
         seq = ({16'd0, sector} == last_end);
         if (seq) st = last_stream;
         last_end = {16'd0, sector} + {32'd0, len >> sit_pkg::SECTOR_SHIFT};
         last_stream = st;
         r.stream_hint = {1'b0, st} + 6'd2;
         r.was_sequential = seq;
         owed.push_back(r);
      endfunction

      task report(string what);
         errors++;
         $display("[%0t] error: %s", $time, what);
      endtask

      task check_result(sit_pkg::result_type got);
         sit_pkg::result_type want;
         if (owed.size() == 0) begin
            report($sformatf("unexpected result beat %p", got));
            return;
         end
         want = owed.pop_front();
         if (got.stream_hint !== want.stream_hint)
            report($sformatf("stream_hint %0d, want %0d", got.stream_hint, want.stream_hint));
         if (got.was_sequential !== want.was_sequential)
            report($sformatf("was_sequential %b, want %b", got.was_sequential,
                             want.was_sequential));
         if (got.out_of_range !== want.out_of_range)
            report($sformatf("out_of_range %b, want %b", got.out_of_range, want.out_of_range));
      endtask
   endclass

   logic clock;
   logic reset;
   bit   calm;      // suppress random idling on both sides while set
   logic [sit_pkg::NOW_W-1:0] now_cursor;

   sit_req_if req_ch();
   sit_rsp_if rsp_ch();
   sit_csr_if csr_ch();

   hint_scoreboard sb = new();

   io_stream_id_tagger dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   always begin
      clock = 1'b0; #5;
      clock = 1'b1; #5;
   end

   // Stall the response side at random, except in the calm stretch.
   always @(posedge clock) begin
      if (reset)
         rsp_ch.ready <= 1'b0;
      else
         rsp_ch.ready <= calm || ($urandom_range(0, 99) >= 8);
   end

   // Check each response beat against the oldest owed result.
   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready)
         sb.check_result('{rsp_ch.stream_hint, rsp_ch.was_sequential, rsp_ch.out_of_range});
   end

   // Send one request beat; valid stays high across back-to-back beats.
   task automatic send_req(logic [sit_pkg::SECTOR_W-1:0] sector,
                           logic [sit_pkg::LEN_W-1:0] len,
                           logic [sit_pkg::NOW_W-1:0] now);
      if (!calm && $urandom_range(0, 99) < 8) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.start_sector <= sector;
      req_ch.length_bytes <= len;
      req_ch.now_ns <= now;
      do @(posedge clock); while (!req_ch.ready);
      sb.note_request(sector, len, now);
   endtask

   // Write one register; valid stays high across back-to-back writes.
   task automatic write_reg(sit_pkg::csr_index_type idx,
                            logic [sit_pkg::CSR_DATA_W-1:0] val);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.data <= val;
      do @(posedge clock); while (!csr_ch.ready);
      sb.set_reg(idx, val);
   endtask

   // Drop valid, drain every owed result, then let the pipeline settle.
   task automatic drain();
      req_ch.valid <= 1'b0;
      while (sb.owed.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   // Advance the request clock: mostly small steps, sometimes long idles,
   // backward jumps or a fully random time.
   function automatic logic [sit_pkg::NOW_W-1:0] next_now();
      int unsigned pick;
      pick = $urandom_range(0, 99);
      if (pick < 70)
         now_cursor = now_cursor + $urandom_range(0, 2000000000);
      else if (pick < 90)
         now_cursor = now_cursor + 64'd1000000000 * $urandom_range(1, 40);
      else if (pick < 95)
         now_cursor = now_cursor - $urandom_range(1, 2000000000);
      else
         now_cursor = {$urandom, $urandom};
      return now_cursor;
   endfunction

   // Build one random request, leaning on sequential runs and a few hot chunks.
   task automatic random_req();
      int unsigned                  pick;
      logic [63:0]                  base;
      logic [63:0]                  chunk;
      logic [63:0]                  wide;
      logic [sit_pkg::SECTOR_W-1:0] sector;
      logic [sit_pkg::LEN_W-1:0]    len;
      pick = $urandom_range(0, 99);
      if ($urandom_range(0, 9) == 0)
         len = $urandom;
      else
         len = $urandom_range(0, 256) << sit_pkg::SECTOR_SHIFT;
      if (pick < 40 && sb.last_end < (64'd1 << sit_pkg::SECTOR_W)) begin
         sector = sb.last_end[sit_pkg::SECTOR_W-1:0];
      end else if (pick < 90 && sb.chunk_size != 0) begin
         chunk = (pick < 75) ? (($urandom_range(0, 9) == 0) ? 4095 : $urandom_range(0, 7))
                             : $urandom_range(0, sit_pkg::CHUNKS_DEFAULT - 1);
         base = chunk * sb.chunk_size + $urandom_range(0, sb.chunk_size - 1);
         sector = sit_pkg::SECTOR_W'(base >> sit_pkg::SECTOR_SHIFT);
      end else begin
         wide = {$urandom, $urandom};
         sector = wide[sit_pkg::SECTOR_W-1:0];
      end
      send_req(sector, len, next_now());
   endtask

   task automatic random_phase(logic [sit_pkg::CSR_DATA_W-1:0] csize,
                               logic [sit_pkg::CSR_DATA_W-1:0] decay,
                               logic [sit_pkg::CSR_DATA_W-1:0] nstreams, int n);
      write_reg(sit_pkg::CSR_CHUNK_SIZE, csize);
      write_reg(sit_pkg::CSR_DECAY, decay);
      write_reg(sit_pkg::CSR_STREAMS, nstreams);
      csr_ch.valid <= 1'b0;
      repeat (n) random_req();
      drain();
   endtask

   initial begin
      reset <= 1'b1;
      calm = 1'b0;
      now_cursor = '0;
      req_ch.valid <= 1'b0;
      req_ch.start_sector <= '0;
      req_ch.length_bytes <= '0;
      req_ch.now_ns <= '0;
      csr_ch.valid <= 1'b0;
      csr_ch.index <= sit_pkg::CSR_CHUNK_SIZE;
      csr_ch.data <= '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Directed beats at reset settings (2 MiB chunks: 4096 sectors each).
      send_req(0, 0, 0);
      send_req(0, 4096, 1);                    // continues the previous request
      send_req(8, 512, 2);                     // continues again
      for (int k = 0; k < 8; k++)
         send_req(5 * 4096 + k * 40, 0, 100 + k); // heat one chunk up the streams
      send_req(24'hFFFFFF, '1, '1);            // last chunk, widest length and time
      send_req(48'h1000000, 0, 5);             // first chunk past the table
      send_req('1, '1, 7);                     // widest sector
      send_req(5 * 4096, 0, 64'd200000000000); // long idle clears the heat
      send_req(5 * 4096 + 1, 0, 1000);         // time runs backward
      send_req(5 * 4096 + 3, 1023, 64'd200000000001);
      send_req(5 * 4096 + 4, 0, 64'd200000000002); // sector after a partial-sector length
      drain();
      now_cursor = 64'd300000000000;

      random_phase(512, 1, 0, 150);                   // smallest chunk, fastest decay, no streams
      random_phase(31'h7FFFFFFF, 16'hFFFF, 31, 200);  // largest values everywhere
      random_phase(0, 0, 1, 30);                      // zero chunk size: all out of range
      random_phase(4096, 0, 2, 150);                  // decay disabled
      calm = 1'b1;
      random_phase(2097152, 10, 16, 300);             // back to reset values, no idling
      calm = 1'b0;
      repeat (3)
         random_phase($urandom_range(512, 1 << 24), $urandom_range(1, 20),
                      $urandom_range(0, 31), 120);

      if (sb.errors == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

   initial begin
      #8000000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end
endmodule

### filelist.f
hdl/sit_pkg.sv
hdl/sit_if.sv
hdl/sit_front.sv
hdl/sit_queue.sv
hdl/sit_back.sv
hdl/io_stream_id_tagger.sv
tb/sv/tb_top.sv
